// ===== sv/isa_dma_page_chunk_programmer_assert.svh =====
// Assertion macros of the DMA chunk programmer, used by idpc_ctrl.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ISA_DMA_PAGE_CHUNK_PROGRAMMER_ASSERT_SVH
`define ISA_DMA_PAGE_CHUNK_PROGRAMMER_ASSERT_SVH

// Checked on every rising edge outside reset.
`define IDPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define IDPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/idpc_pkg.sv =====
// Types, constants and port tables of the DMA chunk programmer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package idpc_pkg;

  localparam int ADDR_W  = 24;
  localparam int LEN_W   = 24;
  localparam int CHUNK_W = 17;
  localparam int OFS_W   = 16;
  localparam int PAGE_W  = 8;

  localparam logic [CHUNK_W-1:0] PAGE_UNITS = 17'h10000;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_NEXT  = 1'b1;

  typedef logic [3:0] step_t;
  localparam step_t STEP_MASK_ON  = 4'd0;
  localparam step_t STEP_MODE     = 4'd1;
  localparam step_t STEP_FLIP_A   = 4'd2;
  localparam step_t STEP_ADDR_LO  = 4'd3;
  localparam step_t STEP_ADDR_HI  = 4'd4;
  localparam step_t STEP_PAGE     = 4'd5;
  localparam step_t STEP_FLIP_B   = 4'd6;
  localparam step_t STEP_COUNT_LO = 4'd7;
  localparam step_t STEP_COUNT_HI = 4'd8;
  localparam step_t STEP_MASK_OFF = 4'd9;

  localparam logic [7:0] MASK_PORT_BYTE = 8'h0a;
  localparam logic [7:0] MODE_PORT_BYTE = 8'h0b;
  localparam logic [7:0] FLIP_PORT_BYTE = 8'h0c;
  localparam logic [7:0] MASK_PORT_WORD = 8'hd4;
  localparam logic [7:0] MODE_PORT_WORD = 8'hd6;
  localparam logic [7:0] FLIP_PORT_WORD = 8'hd8;
  localparam logic [7:0] MASK_SET_BIT   = 8'h04;

  typedef struct packed {
    logic              kind;
    logic [2:0]        channel;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  length;
    logic [7:0]        mode;
  } in_word_t;

  typedef struct packed {
    logic               write_valid;
    logic [7:0]         port;
    logic [7:0]         data;
    logic [CHUNK_W-1:0] chunk;
    logic [LEN_W-1:0]   remaining;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic  load_in;
    logic  calc;
    logic  out_load;
    step_t step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic done;
  } dp_stat_t;

  function automatic logic [7:0] addr_port(input logic [2:0] ch);
    logic [7:0] p;
    unique case (ch)
      3'd0:    p = 8'h00;
      3'd1:    p = 8'h02;
      3'd2:    p = 8'h04;
      3'd3:    p = 8'h06;
      3'd4:    p = 8'hc0;
      3'd5:    p = 8'hc2;
      3'd6:    p = 8'hc4;
      default: p = 8'hc6;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] count_port(input logic [2:0] ch);
    logic [7:0] p;
    unique case (ch)
      3'd0:    p = 8'h01;
      3'd1:    p = 8'h03;
      3'd2:    p = 8'h05;
      3'd3:    p = 8'h07;
      3'd4:    p = 8'hc1;
      3'd5:    p = 8'hc3;
      3'd6:    p = 8'hc5;
      default: p = 8'hc7;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] page_port(input logic [2:0] ch);
    logic [7:0] p;
    unique case (ch)
      3'd0:    p = 8'h87;
      3'd1:    p = 8'h83;
      3'd2:    p = 8'h81;
      3'd3:    p = 8'h82;
      3'd4:    p = 8'h8f;
      3'd5:    p = 8'h8b;
      3'd6:    p = 8'h89;
      default: p = 8'h8a;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== sv/idpc_dpath.sv =====
// Datapath of the DMA chunk programmer: input register, per-channel state,
// chunk arithmetic and the output word register. Uses idpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module idpc_dpath #(
  parameter int NUM_CHANNELS = 8
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  idpc_pkg::in_word_t   in_word_i,
  input  idpc_pkg::ctrl_cmd_t  cmd_i,
  output idpc_pkg::dp_stat_t   stat_o,
  output idpc_pkg::out_word_t  out_word_o
);
  import idpc_pkg::*;

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  in_word_t           in_q;
  logic [CHUNK_W-1:0] chunk_q;
  logic [LEN_W-1:0]   rem_q;
  logic [PAGE_W-1:0]  page_q;
  logic [OFS_W-1:0]   offset_q;
  logic               done_q;
  out_word_t          out_q;

  logic [LEN_W-1:0]   left_q  [NUM_CHANNELS];
  logic [PAGE_W-1:0]  npage_q [NUM_CHANNELS];
  logic [7:0]         mode_q  [NUM_CHANNELS];

  logic [CH_W-1:0]    idx;
  logic               ch_bad;
  logic               word_ch;
  logic [ADDR_W-1:0]  addr_u;
  logic [LEN_W-1:0]   len_u;
  logic [CHUNK_W-1:0] room;
  logic [CHUNK_W-1:0] start_chunk;
  logic [LEN_W-1:0]   start_left;
  logic [LEN_W-1:0]   cur_left;
  logic               next_big;
  logic [CHUNK_W-1:0] next_chunk;
  logic [LEN_W-1:0]   next_left;
  logic [OFS_W-1:0]   count_val;
  logic [7:0]         sel_byte;
  logic [7:0]         mask_port;
  logic [7:0]         mode_port;
  logic [7:0]         flip_port;
  out_word_t          word_d;

  assign idx     = in_q.channel[CH_W-1:0];
  assign ch_bad  = 4'(in_q.channel) >= 4'(NUM_CHANNELS);
  assign word_ch = in_q.channel[2];

  // Word channels count in 16-bit units, so address and length are halved.
  assign addr_u = word_ch ? {1'b0, in_q.address[ADDR_W-1:1]} : in_q.address;
  assign len_u  = word_ch ? {1'b0, in_q.length[LEN_W-1:1]}  : in_q.length;

  assign room        = PAGE_UNITS - {1'b0, addr_u[OFS_W-1:0]};
  assign start_chunk = (len_u < LEN_W'(room)) ? len_u[CHUNK_W-1:0] : room;
  assign start_left  = len_u - LEN_W'(start_chunk);

  assign cur_left   = left_q[idx];
  assign next_big   = cur_left > LEN_W'(PAGE_UNITS);
  assign next_chunk = next_big ? PAGE_UNITS : cur_left[CHUNK_W-1:0];
  assign next_left  = next_big ? (cur_left - LEN_W'(PAGE_UNITS)) : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_word_i;
    end
    if (cmd_i.out_load) begin
      out_q <= word_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      if (in_q.kind == KIND_START) begin
        chunk_q  <= start_chunk;
        rem_q    <= start_left;
        page_q   <= addr_u[ADDR_W-1:OFS_W];
        offset_q <= addr_u[OFS_W-1:0];
      end else begin
        chunk_q  <= next_chunk;
        rem_q    <= next_left;
        page_q   <= npage_q[idx];
        offset_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        left_q[i]  <= '0;
        npage_q[i] <= '0;
        mode_q[i]  <= '0;
      end
    end else if (cmd_i.calc) begin
      if (ch_bad) begin
        done_q <= 1'b1;
      end else if (in_q.kind == KIND_START) begin
        done_q       <= (start_chunk == '0);
        left_q[idx]  <= start_left;
        npage_q[idx] <= addr_u[ADDR_W-1:OFS_W] + 8'd1;
        mode_q[idx]  <= in_q.mode | {6'b0, in_q.channel[1:0]};
      end else begin
        done_q <= (cur_left == '0);
        if (cur_left != '0) begin
          left_q[idx]  <= next_left;
          npage_q[idx] <= npage_q[idx] + 8'd1;
        end
      end
    end
  end

  assign count_val = OFS_W'(chunk_q - 17'd1);
  assign sel_byte  = {6'b0, in_q.channel[1:0]};
  assign mask_port = word_ch ? MASK_PORT_WORD : MASK_PORT_BYTE;
  assign mode_port = word_ch ? MODE_PORT_WORD : MODE_PORT_BYTE;
  assign flip_port = word_ch ? FLIP_PORT_WORD : FLIP_PORT_BYTE;

  always_comb begin
    word_d             = '0;
    word_d.write_valid = 1'b1;
    word_d.chunk       = chunk_q;
    word_d.remaining   = rem_q;
    word_d.last        = (cmd_i.step == STEP_MASK_OFF);
    unique case (cmd_i.step) inside
      STEP_MASK_ON: begin
        word_d.port = mask_port;
        word_d.data = sel_byte | MASK_SET_BIT;
      end
      STEP_MODE: begin
        word_d.port = mode_port;
        word_d.data = mode_q[idx];
      end
      STEP_FLIP_A, STEP_FLIP_B: begin
        word_d.port = flip_port;
        word_d.data = 8'h00;
      end
      STEP_ADDR_LO: begin
        word_d.port = addr_port(in_q.channel);
        word_d.data = offset_q[7:0];
      end
      STEP_ADDR_HI: begin
        word_d.port = addr_port(in_q.channel);
        word_d.data = offset_q[15:8];
      end
      STEP_PAGE: begin
        word_d.port = page_port(in_q.channel);
        word_d.data = page_q;
      end
      STEP_COUNT_LO: begin
        word_d.port = count_port(in_q.channel);
        word_d.data = count_val[7:0];
      end
      STEP_COUNT_HI: begin
        word_d.port = count_port(in_q.channel);
        word_d.data = count_val[15:8];
      end
      STEP_MASK_OFF: begin
        word_d.port = mask_port;
        word_d.data = sel_byte;
      end
      default: begin
        word_d.port = 8'h00;
        word_d.data = 8'h00;
      end
    endcase
    // A finished transfer or an ignored channel answers with one empty word.
    if (done_q) begin
      word_d      = '0;
      word_d.last = 1'b1;
    end
  end

  assign stat_o.done = done_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

// ===== sv/idpc_ctrl.sv =====
// Controller of the DMA chunk programmer: sequencing state machine, write
// step counter and output valid. Uses idpc_pkg and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none

`include "isa_dma_page_chunk_programmer_assert.svh"

module idpc_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  input  idpc_pkg::dp_stat_t   stat_i,
  output idpc_pkg::ctrl_cmd_t  cmd_o
);
  import idpc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_q, state_d;
  step_t      step_q, step_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       last_load;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign last_load = stat_i.done || (step_q == STEP_MASK_OFF);

  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    cmd_o         = '0;
    cmd_o.step    = step_q;
    in_stall_o    = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        step_d     = STEP_MASK_ON;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          if (last_load) begin
            state_d = S_IDLE;
          end else begin
            step_d = step_q + 4'd1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The output register holds its word until the far side takes it.
  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= STEP_MASK_ON;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `IDPC_ASSERT(a_accept_to_calc, (in_valid_i && !in_stall_o) |=> (state_q == S_CALC), "accepted word did not start a calculation")
  `IDPC_ASSERT_ALWAYS(a_step_range, !rst_ni || (step_q <= STEP_MASK_OFF), "write step counter out of range")
  `IDPC_ASSERT(a_no_overwrite, (out_valid_q && out_stall_i) |-> !cmd_o.out_load, "stalled output word overwritten")
  `IDPC_ASSERT(a_last_to_idle, (cmd_o.out_load && last_load) |=> (state_q == S_IDLE), "sequence did not end after its last word")

endmodule

`default_nettype wire

// ===== sv/isa_dma_page_chunk_programmer.sv =====
// Top level of the ISA DMA page chunk programmer: controller plus datapath.
// Depends on idpc_pkg, idpc_ctrl and idpc_dpath.
//
//   Channel   Direction   Handshake                  Word
//   input     in          in_valid_i / in_stall_o    idpc_pkg::in_word_t
//   output    out         out_valid_o / out_stall_i  idpc_pkg::out_word_t
//
// An input word is taken only while the sequencer is idle; the calc state
// then computes the chunk and updates the channel state.
// A programming step yields ten output words, one per cycle while the output
// is not stalled; a done answer yields one empty word. A new input is taken
// only once the last word of the previous one is loaded into the output register.
// Reset clears all per-channel state to zero; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module isa_dma_page_chunk_programmer #(
  parameter int NUM_CHANNELS = 8
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  idpc_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output idpc_pkg::out_word_t  out_word_o
);
  import idpc_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  idpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  idpc_dpath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_word_o (out_word_o)
  );

endmodule

`default_nettype wire
